// ===== hdl/positional_list_insert_delete_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PLI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define PLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pli_pkg.sv =====
`default_nettype none
package pli_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 6;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the incoming transaction
      logic commit;  // apply the operation and load the result register
   } cmd_type;

endpackage
`default_nettype wire

// ===== hdl/pli_req_if.sv =====
`default_nettype none
interface pli_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic signed [pli_pkg::VALUE_W-1:0]  value;
   logic        [pli_pkg::POS_W-1:0]    position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink   (input valid, input op, input value, input position, output ready);
endinterface
`default_nettype wire

// ===== hdl/pli_rsp_if.sv =====
`default_nettype none
interface pli_rsp_if;
   logic                                valid;
   logic                                ready;
   pli_pkg::status_type                 status;
   logic        [pli_pkg::COUNT_W-1:0]  entry_count;
   logic signed [pli_pkg::VALUE_W-1:0]  removed_value;

   modport source (output valid, output status, output entry_count, output removed_value,
                   input ready);
   modport sink   (input valid, input status, input entry_count, input removed_value,
                   output ready);
endinterface
`default_nettype wire

// ===== hdl/positional_list_insert_delete.sv =====
`default_nettype none
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   op, value, position
// rsp       out  valid/ready   status, entry_count, removed_value
//
// Each transaction is first captured and then applied to the list in an update step.
// All cells shift in parallel in the update cycle, so the cost does not depend on position.
// A new request is accepted while the previous result waits in the output register.
// The update cycle stalls while the output register holds a result not yet taken.
// Synchronous reset empties the list; cell contents are not cleared.
module positional_list_insert_delete #(
   parameter int DEPTH = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   pli_req_if.sink    req,
   pli_rsp_if.source  rsp
);
   import pli_pkg::*;

   cmd_type cmd;

   // Sequencing of capture and update.
   pli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // List storage, status decision and result register.
   pli_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req.op),
      .req_value         (req.value),
      .req_position      (req.position),
      .rsp_status        (rsp.status),
      .rsp_entry_count   (rsp.entry_count),
      .rsp_removed_value (rsp.removed_value)
   );
endmodule
`default_nettype wire

// ===== hdl/pli_ctrl.sv =====
`default_nettype none
module pli_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pli_pkg::cmd_type      cmd
);
   import pli_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_EXEC: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Result valid flag: set by a commit, cleared when the result is taken.
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/pli_datapath.sv =====
`default_nettype none
module pli_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pli_pkg::cmd_type                    cmd,
   input  wire logic                                req_op,
   input  wire logic signed [pli_pkg::VALUE_W-1:0]  req_value,
   input  wire logic        [pli_pkg::POS_W-1:0]    req_position,
   output pli_pkg::status_type                      rsp_status,
   output logic             [pli_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic signed      [pli_pkg::VALUE_W-1:0]  rsp_removed_value
);
   import pli_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = POS_W + 1;

   // Captured transaction.
   op_type                    op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic        [POS_W-1:0]   pos_ff;

   // List cells and fill count.
   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] entries_in [DEPTH];
   logic        [CNT_W-1:0]   fill_ff, fill_in;

   // Result register.
   status_type                status_ff, status_in;
   logic        [COUNT_W-1:0] count_ff;
   logic signed [VALUE_W-1:0] removed_ff, removed_in;

   logic             full, empty, op_ok;
   logic [CMP_W-1:0] pos_ext, fill_ext;
   logic [IDX_W-1:0] idx;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign pos_ext  = CMP_W'(pos_ff);
   assign fill_ext = CMP_W'(fill_ff);
   assign idx      = IDX_W'(pos_ff - POS_W'(1));

   // Status decision: capacity first, then position range.
   always_comb begin
      status_in = ST_OK;
      if (op_ff == OP_INSERT) begin
         if (full) begin
            status_in = ST_FULL;
         end else if ((pos_ff == '0) || (pos_ext > fill_ext + CMP_W'(1))) begin
            status_in = ST_BAD_POS;
         end
      end else begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else if ((pos_ff == '0) || (pos_ext > fill_ext)) begin
            status_in = ST_BAD_POS;
         end
      end
   end

   assign op_ok = (status_in == ST_OK);

   // Removed value comes from the addressed cell on a good delete.
   always_comb begin
      removed_in = '0;
      if (op_ok && (op_ff == OP_DELETE)) removed_in = entries_ff[idx];
   end

   // New fill count.
   always_comb begin
      fill_in = fill_ff;
      if (op_ok) begin
         if (op_ff == OP_INSERT) begin
            fill_in = fill_ff + CNT_W'(1);
         end else begin
            fill_in = fill_ff - CNT_W'(1);
         end
      end
   end

   // Each cell takes its own value, its lower neighbor's, its upper neighbor's or the inserted value.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] from_prev, from_next;

      if (i == 0) begin : g_first
         assign from_prev = value_ff;
      end else begin : g_mid
         assign from_prev = entries_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign from_next = entries_ff[i];
      end else begin : g_inner
         assign from_next = entries_ff[i+1];
      end

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (IDX_W'(i) == idx) begin
            entries_in[i] = (op_ff == OP_INSERT) ? value_ff : from_next;
         end else if (IDX_W'(i) > idx) begin
            entries_in[i] = (op_ff == OP_INSERT) ? from_prev : from_next;
         end
      end
   end

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   // List update and result register.
   always_ff @(posedge clock) begin
      if (cmd.commit && op_ok) begin
         entries_ff <= entries_in;
      end
      if (cmd.commit) begin
         status_ff  <= status_in;
         count_ff   <= COUNT_W'(fill_in);
         removed_ff <= removed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.commit) begin
         fill_ff <= fill_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_removed_value = removed_ff;
endmodule
`default_nettype wire

// ===== hdl/pli_checker.sv =====
`default_nettype none
`include "positional_list_insert_delete_macros.svh"
module pli_checker #(
   parameter int DEPTH = 16
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire pli_pkg::status_type                 rsp_status,
   input wire logic        [pli_pkg::COUNT_W-1:0]  rsp_entry_count,
   input wire logic signed [pli_pkg::VALUE_W-1:0]  rsp_removed_value
);
   import pli_pkg::*;

   logic rsp_stall, req_take, count_ok, removed_ok, flags_ok;

   // Handshake conditions and per-result checks.
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign req_take   = req_valid && req_ready;
   assign count_ok   = (rsp_entry_count <= COUNT_W'(DEPTH));
   assign removed_ok = (rsp_status == ST_OK) || (rsp_removed_value == '0);
   assign flags_ok   = (rsp_status != ST_FULL || rsp_entry_count == COUNT_W'(DEPTH)) &&
                       (rsp_status != ST_EMPTY || rsp_entry_count == '0);

   // A result must stay offered until it is taken.
   `PLI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "result dropped in stall")

   // The block works on one transaction at a time.
   `PLI_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_take, !req_ready, "accepted while busy")

   // Count stays within capacity.
   `PLI_ASSERT(a_count_range, clock, reset, !rsp_valid || count_ok, "entry count above capacity")

   // Only a successful operation returns a nonzero value.
   `PLI_ASSERT(a_removed_zero, clock, reset, !rsp_valid || removed_ok, "removed value on failure")

   // Full and empty reports agree with the count.
   `PLI_ASSERT(a_full_empty, clock, reset, !rsp_valid || flags_ok, "status disagrees with count")
endmodule

bind positional_list_insert_delete pli_checker #(
   .DEPTH (DEPTH)
) u_pli_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_entry_count   (rsp.entry_count),
   .rsp_removed_value (rsp.removed_value)
);
`default_nettype wire
